FILE: rtl/core/assert_macros.svh
// Assertion macros shared by the PES header generator RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Check that prop holds at every rising clk edge outside reset.
`define ASSERT_PROP(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("assertion failed");
// Check that expr is never true at a rising clk edge outside reset.
`define ASSERT_NEVER(label, clk, rst_n, expr) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
    else $error("forbidden condition seen");
`else
`define ASSERT_PROP(label, clk, rst_n, prop)
`define ASSERT_NEVER(label, clk, rst_n, expr)
`endif
`endif

FILE: rtl/core/pesg_pkg.sv
// Types and constants shared by the PES header generator modules.
package pesg_pkg;

  localparam int unsigned TS_W      = 33;
  localparam int unsigned LEN_W     = 16;
  localparam int unsigned TICK_W    = 24;
  localparam int unsigned CFG_DW    = 24;
  localparam int unsigned CFG_IW    = 2;
  localparam int unsigned BCNT_W    = 5;   // up to 23 bytes per sample

  // Configuration register indexes
  localparam logic [CFG_IW-1:0] CFG_PTS_TICK  = 2'd0;
  localparam logic [CFG_IW-1:0] CFG_ANNEXB    = 2'd1;
  localparam logic [CFG_IW-1:0] CFG_STREAM_ID = 2'd2;

  localparam logic [TICK_W-1:0] PTS_TICK_RST    = 24'd3750;
  localparam logic [7:0]        STREAM_ID_RST   = 8'hE0;
  localparam logic [TS_W-1:0]   RUNNING_PTS_RST = 33'd1;

  // Header byte constants
  localparam logic [7:0] FLAGS_FIXED   = 8'h80;
  localparam logic [7:0] FLAGS_PTS     = 8'h80;
  localparam logic [7:0] FLAGS_PTS_DTS = 8'hC0;
  localparam logic [7:0] FLAGS_NONE    = 8'h00;
  localparam logic [3:0] PFX_PTS       = 4'h2;
  localparam logic [3:0] PFX_PTS_DTS   = 4'h3;
  localparam logic [3:0] PFX_DTS       = 4'h1;
  localparam logic [4:0] TS_BYTES      = 5'd5;
  localparam logic [4:0] FIXED_BYTES   = 5'd9;
  localparam logic [4:0] SC_BYTES      = 5'd4;

  typedef struct packed {
    logic [15:0]     payload_size;
    logic            is_parameter_set;
    logic            pts_valid;
    logic [TS_W-1:0] pts;
    logic            dts_valid;
    logic [TS_W-1:0] dts;
  } pes_in_t;

  typedef struct packed {
    logic [7:0] header_byte;
    logic       last;
  } pes_out_t;

  // Per-sample work descriptor handed to the byte serializer
  typedef struct packed {
    logic [LEN_W-1:0]  pkt_len;
    logic              pts_on;
    logic              dts_on;
    logic [TS_W-1:0]   pts;
    logic [TS_W-1:0]   dts;
    logic [BCNT_W-1:0] n_bytes;
  } pesg_desc_t;

endpackage

FILE: rtl/core/pes_header_generator.sv
// Top level of the PES header generator: sample intake, running PTS, config.
//
//  channel   | handshake              | payload
//  ----------+------------------------+-------------------------------------
//  in        | in_valid_i/in_ready_o  | in_data_i  (pes_in_t, one sample)
//  out       | out_valid_o/out_ready_i| out_data_o (pes_out_t, one byte)
//  cfg       | cfg_we_i               | cfg_idx_i, cfg_wdata_i
//
// Each sample yields 9 to 23 words, one per cycle while out_ready_i is high; the
// byte serializer and its single output port set the pace.
// A sample moves from the intake register into the serializer on the cycle its
// predecessor's last word is produced, so samples stream without gaps.
// Reset clears all valid flags, loads the register defaults and sets the
// running PTS to one. A stalled output holds its word; the intake register
// then fills and in_ready_o drops until the serializer frees it.
`include "assert_macros.svh"
module pes_header_generator
  import pesg_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  pes_in_t           in_data_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output pes_out_t          out_data_o,
  input  logic              cfg_we_i,
  input  logic [CFG_IW-1:0] cfg_idx_i,
  input  logic [CFG_DW-1:0] cfg_wdata_i
);

  logic [TICK_W-1:0] pts_tick_q;
  logic              annexb_q;
  logic [7:0]        stream_id_q;
  logic [TS_W-1:0]   running_pts_q, running_pts_d;

  pesg_desc_t pend_q, pend_d;
  logic       pend_valid_q;
  logic       desc_ready;
  logic       in_acc;
  logic       pts_on, dts_on, adv;
  logic [BCNT_W-1:0] hdr_len;

  // Hold a new sample whenever the intake slot is empty or draining this cycle
  assign in_ready_o = !pend_valid_q || desc_ready;
  assign in_acc     = in_valid_i && in_ready_o;

  assign pts_on  = !in_data_i.is_parameter_set;
  assign dts_on  = pts_on && in_data_i.dts_valid;
  assign adv     = pts_on && !in_data_i.pts_valid;
  assign hdr_len = (pts_on ? TS_BYTES : 5'd0) + (dts_on ? TS_BYTES : 5'd0);

  // Advance the running PTS modulo 2^33 for non-parameter-set samples without their own PTS
  assign running_pts_d = running_pts_q + {{(TS_W-TICK_W){1'b0}}, pts_tick_q};

  always_comb begin
    pend_d.pkt_len = in_data_i.payload_size + LEN_W'(3) + LEN_W'(hdr_len)
                   + (annexb_q ? LEN_W'(SC_BYTES) : LEN_W'(0));
    pend_d.pts_on  = pts_on;
    pend_d.dts_on  = dts_on;
    pend_d.pts     = adv ? running_pts_d : in_data_i.pts;
    pend_d.dts     = in_data_i.dts;
    pend_d.n_bytes = FIXED_BYTES + hdr_len + (annexb_q ? SC_BYTES : 5'd0);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pts_tick_q    <= PTS_TICK_RST;
      annexb_q      <= 1'b0;
      stream_id_q   <= STREAM_ID_RST;
      running_pts_q <= RUNNING_PTS_RST;
      pend_valid_q  <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_PTS_TICK:  pts_tick_q  <= cfg_wdata_i[TICK_W-1:0];
          CFG_ANNEXB:    annexb_q    <= cfg_wdata_i[0];
          CFG_STREAM_ID: stream_id_q <= cfg_wdata_i[7:0];
          default: ;   // drop writes beyond the register list
        endcase
      end
      if (in_acc && adv) running_pts_q <= running_pts_d;
      if (in_acc)          pend_valid_q <= 1'b1;
      else if (desc_ready) pend_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) pend_q <= pend_d;
  end

  pesg_serializer u_ser (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .desc_valid_i (pend_valid_q),
    .desc_ready_o (desc_ready),
    .desc_i       (pend_q),
    .stream_id_i  (stream_id_q),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .out_data_o   (out_data_o)
  );

  `ASSERT_PROP(a_rpts_only_on_accept, clk_i, rst_ni, !in_acc |=> $stable(running_pts_q))
  `ASSERT_PROP(a_pset_no_ts, clk_i, rst_ni, (in_acc && in_data_i.is_parameter_set) |=> (!pend_q.pts_on && !pend_q.dts_on && $stable(running_pts_q)))
  `ASSERT_PROP(a_pend_holds, clk_i, rst_ni, (pend_valid_q && !desc_ready) |=> (pend_valid_q && $stable(pend_q)))

endmodule

FILE: rtl/core/pesg_serializer.sv
// Byte serializer: walks one sample descriptor out as header words.
`include "assert_macros.svh"
module pesg_serializer
  import pesg_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       desc_valid_i,
  output logic       desc_ready_o,
  input  pesg_desc_t desc_i,
  input  logic [7:0] stream_id_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output pes_out_t   out_data_o
);

  function automatic logic [7:0] ts_byte(input logic [3:0] pfx, input logic [TS_W-1:0] ts,
                                         input logic [2:0] k);
    logic [7:0] b;
    case (k)
      3'd0:    b = {pfx, ts[32:30], 1'b1};
      3'd1:    b = ts[29:22];
      3'd2:    b = {ts[21:15], 1'b1};
      3'd3:    b = ts[14:7];
      3'd4:    b = {ts[6:0], 1'b1};
      default: b = 8'h00;
    endcase
    return b;
  endfunction

  pesg_desc_t        cur_q;
  logic              cur_valid_q;
  logic [BCNT_W-1:0] idx_q;
  pes_out_t          out_q;
  logic              out_valid_q;

  logic              emit, fin, load;
  logic [BCNT_W-1:0] j, hdr_len, sc_pos;
  logic [7:0]        byte_d;
  logic [3:0]        pts_pfx;

  assign emit         = cur_valid_q && (!out_valid_q || out_ready_i);
  assign fin          = emit && (idx_q == cur_q.n_bytes - 5'd1);
  assign desc_ready_o = !cur_valid_q || fin;
  assign load         = desc_valid_i && desc_ready_o;

  assign hdr_len = (cur_q.pts_on ? TS_BYTES : 5'd0) + (cur_q.dts_on ? TS_BYTES : 5'd0);
  assign j       = idx_q - FIXED_BYTES;
  assign sc_pos  = j - hdr_len;
  assign pts_pfx = cur_q.dts_on ? PFX_PTS_DTS : PFX_PTS;

  always_comb begin
    byte_d = 8'h00;
    case (idx_q)
      5'd0, 5'd1: byte_d = 8'h00;
      5'd2:       byte_d = 8'h01;
      5'd3:       byte_d = stream_id_i;
      5'd4:       byte_d = cur_q.pkt_len[15:8];
      5'd5:       byte_d = cur_q.pkt_len[7:0];
      5'd6:       byte_d = FLAGS_FIXED;
      5'd7:       byte_d = cur_q.pts_on ? (cur_q.dts_on ? FLAGS_PTS_DTS : FLAGS_PTS)
                                        : FLAGS_NONE;
      5'd8:       byte_d = {3'b000, hdr_len};
      default: begin
        if (j < hdr_len) begin
          if (j < TS_BYTES) byte_d = ts_byte(pts_pfx, cur_q.pts, j[2:0]);
          else              byte_d = ts_byte(PFX_DTS, cur_q.dts, 3'(j - TS_BYTES));
        end else begin
          // trailing Annex B start code 00 00 00 01
          byte_d = (sc_pos == SC_BYTES - 5'd1) ? 8'h01 : 8'h00;
        end
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_valid_q <= 1'b0;
      idx_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (load) begin
        cur_valid_q <= 1'b1;
        idx_q       <= '0;
      end else if (fin) begin
        cur_valid_q <= 1'b0;
      end else if (emit) begin
        idx_q <= idx_q + 5'd1;
      end
      if (emit)             out_valid_q <= 1'b1;
      else if (out_ready_i) out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) cur_q <= desc_i;
    if (emit) begin
      out_q.header_byte <= byte_d;
      out_q.last        <= (idx_q == cur_q.n_bytes - 5'd1);
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  `ASSERT_PROP(a_idx_in_range, clk_i, rst_ni, cur_valid_q |-> (idx_q < cur_q.n_bytes))
  `ASSERT_PROP(a_last_follows_fin, clk_i, rst_ni, fin |=> (out_valid_q && out_q.last))
  `ASSERT_PROP(a_mid_not_last, clk_i, rst_ni, (emit && !fin) |=> !out_q.last)
  `ASSERT_NEVER(a_short_desc, clk_i, rst_ni, cur_valid_q && (cur_q.n_bytes < FIXED_BYTES))

endmodule

FILE: bench/pes_header_checker.sv
// Checker for the PES header generator: predicts every header word and compares it.
`timescale 1ns / 1ps
module pes_header_checker
  import pesg_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  logic              in_ready_i,
  input  pes_in_t           in_data_i,
  input  logic              out_valid_i,
  input  logic              out_ready_i,
  input  pes_out_t          out_data_i,
  input  logic              cfg_we_i,
  input  logic [CFG_IW-1:0] cfg_idx_i,
  input  logic [CFG_DW-1:0] cfg_wdata_i,
  output int unsigned       bytes_due_o,
  output int unsigned       fail_count_o
);

  localparam logic [7:0] MARKER_BYTE    = 8'h80;
  localparam logic [7:0] HAS_PTS        = 8'h80;
  localparam logic [7:0] HAS_PTS_DTS    = 8'hC0;
  localparam logic [7:0] NO_STAMPS      = 8'h00;
  localparam logic [3:0] TAG_PTS_ALONE  = 4'h2;
  localparam logic [3:0] TAG_PTS_BEFORE = 4'h3;
  localparam logic [3:0] TAG_DTS        = 4'h1;

  logic [23:0]     tick_q;
  logic            annexb_q;
  logic [7:0]      sid_q;
  logic [TS_W-1:0] run_pts_q;
  pes_out_t        header_bytes_due[$];
  pes_out_t        want;
  int unsigned     word_no;

  task automatic report(input string msg);
    $display("ERROR: %s", msg);
    fail_count_o++;
  endtask

  // 33-bit stamp split into five bytes, marker bits set
  function automatic logic [39:0] stamp_bytes(input logic [3:0] tag, input logic [TS_W-1:0] ts);
    return {tag, ts[32:30], 1'b1, ts[29:22], ts[21:15], 1'b1, ts[14:7], ts[6:0], 1'b1};
  endfunction

  function automatic void queue_header(input pes_in_t s);
    logic            pts_on;
    logic            dts_on;
    logic [7:0]      hdr_len;
    logic [15:0]     pkt_len;
    logic [TS_W-1:0] pts;
    logic [39:0]     stamps[$];
    logic [7:0]      b[$];
    pes_out_t        w;
    pts_on  = !s.is_parameter_set;
    dts_on  = pts_on && s.dts_valid;
    hdr_len = (pts_on ? 8'd5 : 8'd0) + (dts_on ? 8'd5 : 8'd0);
    pts     = s.pts;
    // advance the running stamp only for timestamped samples without their own
    if (pts_on && !s.pts_valid) begin
      run_pts_q = run_pts_q + {9'd0, tick_q};
      pts = run_pts_q;
    end
    pkt_len = s.payload_size + 16'd3 + {8'd0, hdr_len} + (annexb_q ? 16'd4 : 16'd0);
    b = '{8'h00, 8'h00, 8'h01, sid_q, pkt_len[15:8], pkt_len[7:0], MARKER_BYTE,
          pts_on ? (dts_on ? HAS_PTS_DTS : HAS_PTS) : NO_STAMPS, hdr_len};
    if (pts_on) stamps.push_back(stamp_bytes(dts_on ? TAG_PTS_BEFORE : TAG_PTS_ALONE, pts));
    if (dts_on) stamps.push_back(stamp_bytes(TAG_DTS, s.dts));
    foreach (stamps[k]) begin
      for (int i = 4; i >= 0; i--) b.push_back(stamps[k][8*i +: 8]);
    end
    if (annexb_q) begin
      b.push_back(8'h00);
      b.push_back(8'h00);
      b.push_back(8'h00);
      b.push_back(8'h01);
    end
    foreach (b[i]) begin
      w.header_byte = b[i];
      w.last        = (i == b.size() - 1);
      header_bytes_due.push_back(w);
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tick_q       = 24'd3750;
      annexb_q     = 1'b0;
      sid_q        = 8'hE0;
      run_pts_q    = 33'd1;
      word_no      = 0;
      fail_count_o = 0;
      header_bytes_due.delete();
      bytes_due_o <= 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_PTS_TICK:  tick_q   = cfg_wdata_i[23:0];
          CFG_ANNEXB:    annexb_q = cfg_wdata_i[0];
          CFG_STREAM_ID: sid_q    = cfg_wdata_i[7:0];
          default: ;
        endcase
      end
      if (in_valid_i && in_ready_i) queue_header(in_data_i);
      if (out_valid_i && out_ready_i) begin
        if (header_bytes_due.size() == 0) begin
          report($sformatf("word %0d: unexpected byte %02h last %0b",
                           word_no, out_data_i.header_byte, out_data_i.last));
        end else begin
          want = header_bytes_due.pop_front();
          if (out_data_i.header_byte !== want.header_byte)
            report($sformatf("word %0d: header_byte %02h, predicted %02h",
                             word_no, out_data_i.header_byte, want.header_byte));
          if (out_data_i.last !== want.last)
            report($sformatf("word %0d: last %0b, predicted %0b",
                             word_no, out_data_i.last, want.last));
        end
        word_no++;
      end
      bytes_due_o <= header_bytes_due.size();
    end
  end

endmodule

FILE: bench/tb_pes_header_generator.sv
// Top of the PES header generator testbench: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps
module tb_pes_header_generator;
  import pesg_pkg::*;

  // Cycles without any accepted word before the run is declared hung. The
  // slowest legal stretch is a receiver stall at 65 percent idling; this is
  // far beyond any such run.
  localparam int unsigned STALL_LIMIT    = 2000;
  localparam int unsigned SAMPLES_PER_PH = 87;
  localparam int unsigned SETTLE_CYCLES  = 40;

  logic              clk_i       = 1'b0;
  logic              rst_ni      = 1'b0;
  logic              in_valid_i  = 1'b0;
  logic              in_ready_o;
  pes_in_t           in_data_i   = '0;
  logic              out_valid_o;
  logic              out_ready_i = 1'b0;
  pes_out_t          out_data_o;
  logic              cfg_we_i    = 1'b0;
  logic [CFG_IW-1:0] cfg_idx_i   = CFG_PTS_TICK;
  logic [CFG_DW-1:0] cfg_wdata_i = '0;

  int unsigned send_idle_pct = 35;
  int unsigned recv_idle_pct = 65;
  int unsigned bytes_due;
  int unsigned fail_count;
  int unsigned quiet_cycles  = 0;

  // 8 ns period
  initial begin
    forever #4 clk_i = ~clk_i;
  end

  pes_header_generator dut (.*);

  pes_header_checker u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_i   (in_ready_o),
    .in_data_i    (in_data_i),
    .out_valid_i  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .out_data_i   (out_data_o),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .bytes_due_o  (bytes_due),
    .fail_count_o (fail_count)
  );

  // Receiver: drop ready at random, at the rate of the current phase. With a
  // zero rate ready stays high for the whole phase.
  always @(posedge clk_i) begin
    out_ready_i <= ($urandom_range(99) >= recv_idle_pct);
  end

  // Watchdog: count cycles in which neither channel moves a word; end the
  // run once the count hits the limit.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
        $display("Some tests failed");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  // Offer one sample. Optionally idle first (valid low for a random number of
  // cycles), then raise valid with the payload and hold both until the
  // handshake. Valid stays high on return so back-to-back samples need no gap.
  task automatic send_sample(input pes_in_t s);
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < send_idle_pct);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= s;
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  // Drop valid and wait until every predicted word has come out. Every sample
  // yields at least nine words, so an empty prediction store means the block
  // is idle.
  task automatic wait_drained();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (bytes_due != 0);
  endtask

  // Write all three registers on consecutive cycles. Fill the unused upper
  // data bits with junk; the block must ignore them.
  task automatic write_regs(input logic [23:0] tick, input logic annexb, input logic [7:0] sid);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= CFG_PTS_TICK;
    cfg_wdata_i <= tick;
    @(posedge clk_i);
    cfg_idx_i   <= CFG_ANNEXB;
    cfg_wdata_i <= {23'($urandom), annexb};
    @(posedge clk_i);
    cfg_idx_i   <= CFG_STREAM_ID;
    cfg_wdata_i <= {16'($urandom), sid};
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
  endtask

  function automatic pes_in_t mk(input logic [15:0] size, input logic ps, input logic pv,
                                 input logic [TS_W-1:0] pts, input logic dv,
                                 input logic [TS_W-1:0] dts);
    pes_in_t s;
    s.payload_size     = size;
    s.is_parameter_set = ps;
    s.pts_valid        = pv;
    s.pts              = pts;
    s.dts_valid        = dv;
    s.dts              = dts;
    return s;
  endfunction

  // Timestamps: mostly random over all 33 bits, sometimes the extremes.
  function automatic logic [TS_W-1:0] rand_stamp();
    case ($urandom_range(7))
      0:       return '0;
      1:       return '1;
      default: return {1'($urandom_range(1)), 32'($urandom)};
    endcase
  endfunction

  // Random sample: sizes lean toward the length wrap and tiny payloads now
  // and then; about one in seven is a parameter set.
  function automatic pes_in_t rand_sample();
    logic [15:0] size;
    case ($urandom_range(7))
      0:       size = 16'hFFFF - 16'($urandom_range(25));
      1:       size = 16'($urandom_range(16));
      default: size = 16'($urandom);
    endcase
    return mk(size, $urandom_range(99) < 15, 1'($urandom_range(1)), rand_stamp(),
              1'($urandom_range(1)), rand_stamp());
  endfunction

  initial begin
    // Hold reset, then release it once for the whole run.
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed samples at the reset register values.
    send_sample(mk(16'h0000, 1'b1, 1'b0, '0, 1'b0, '0));          // bare parameter set
    send_sample(mk(16'hFFFF, 1'b1, 1'b1, '1, 1'b1, '1));          // ignored stamps, length wraps
    send_sample(mk(16'h0000, 1'b0, 1'b1, '0, 1'b0, '0));          // zero PTS
    send_sample(mk(16'hFFFF, 1'b0, 1'b1, '1, 1'b0, '0));          // max PTS, length wraps
    send_sample(mk(16'hFFF0, 1'b0, 1'b1, '1, 1'b1, '1));          // max PTS and DTS
    send_sample(mk(16'hFFF3, 1'b0, 1'b1, 33'h0AAAAAAAA, 1'b1, 33'h155555555)); // length 0
    send_sample(mk(16'd100, 1'b0, 1'b0, rand_stamp(), 1'b0, rand_stamp()));   // running PTS
    send_sample(mk(16'd200, 1'b0, 1'b0, rand_stamp(), 1'b1, 33'h123456789));  // running plus DTS
    send_sample(mk(16'd300, 1'b1, 1'b0, rand_stamp(), 1'b1, rand_stamp()));   // running untouched
    send_sample(mk(16'd400, 1'b0, 1'b0, rand_stamp(), 1'b0, rand_stamp()));
    send_sample(mk(16'h5555, 1'b0, 1'b1, 33'h155555555, 1'b1, 33'h0AAAAAAAA));
    send_sample(mk(16'hAAAA, 1'b0, 1'b0, '0, 1'b1, '0));
    wait_drained();

    // Largest tick, trailing start code on, stream id zero.
    write_regs(24'hFFFFFF, 1'b1, 8'h00);
    send_sample(mk(16'hFFFF, 1'b0, 1'b0, '0, 1'b1, '1));
    send_sample(mk(16'h0000, 1'b1, 1'b1, '1, 1'b1, '1));
    send_sample(mk(16'hFFF8, 1'b0, 1'b1, '1, 1'b0, '0));
    send_sample(mk(16'd7, 1'b0, 1'b0, '0, 1'b0, '0));
    wait_drained();

    // Zero tick keeps the running stamp still; stream id all ones.
    write_regs(24'd0, 1'b0, 8'hFF);
    send_sample(mk(16'd1, 1'b0, 1'b0, '0, 1'b1, rand_stamp()));
    send_sample(mk(16'd2, 1'b0, 1'b0, '1, 1'b0, rand_stamp()));
    send_sample(mk(16'd3, 1'b1, 1'b0, '0, 1'b0, '0));

    // Random phases: receiver-heavy idling, sender-heavy idling, then none,
    // each under its own register setting.
    for (int p = 0; p < 3; p++) begin
      wait_drained();
      case (p)
        0: begin
          send_idle_pct = 35;
          recv_idle_pct = 65;
          write_regs(24'($urandom), 1'($urandom_range(1)), 8'($urandom));
        end
        1: begin
          send_idle_pct = 65;
          recv_idle_pct = 35;
          write_regs(24'hFFFFFF - 24'($urandom_range(255)), 1'b1, 8'($urandom));
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
          write_regs(24'($urandom_range(9000)), 1'($urandom_range(1)), 8'hE0);
        end
      endcase
      repeat (SAMPLES_PER_PH) send_sample(rand_sample());
    end

    // Let the last words drain, then give the block time to show any extra.
    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (fail_count == 0) $display("All tests passed");
    else $display("Some tests failed");
    $finish;
  end

endmodule

FILE: pes_header_generator.f
+incdir+rtl/core
rtl/core/pesg_pkg.sv
rtl/core/pesg_serializer.sv
rtl/core/pes_header_generator.sv
bench/pes_header_checker.sv
bench/tb_pes_header_generator.sv
